// ----- rtl/core/iprl_pkg.sv -----
package iprl_pkg;

    // table geometry and field widths
    localparam int TABLE_DEPTH = 1024;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = IDX_W + 1;
    localparam int ADDR_W      = 32;
    localparam int REGION_W    = 16;
    localparam int WORD_W      = 2 * ADDR_W + REGION_W;

    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(TABLE_DEPTH);

    // item command codes
    localparam logic CMD_WRITE  = 1'b0;
    localparam logic CMD_LOOKUP = 1'b1;

    // controller to datapath
    typedef struct packed {
        logic wr;         // store one table entry
        logic start;      // begin search, issue first read
        logic step;       // consume probe data, issue next read
        logic res_miss;   // result is no match
        logic res_check;  // final range check on selected entry
        logic out_load;   // move result into output register
    } iprl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic probe_next; // search interval still open
        logic empty_next; // no entry has start at or below address
    } iprl_status_t;

endpackage

// ----- rtl/core/iprl_dp.sv -----
module iprl_dp (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  iprl_pkg::iprl_cmd_t               cmd,
    output iprl_pkg::iprl_status_t            status,
    input  logic                              cfg_we,
    input  logic [iprl_pkg::CNT_W-1:0]        cfg_entry_count,
    input  logic [iprl_pkg::IDX_W-1:0]        s_entry_index,
    input  logic [iprl_pkg::ADDR_W-1:0]       s_range_start,
    input  logic [iprl_pkg::ADDR_W-1:0]       s_range_end,
    input  logic [iprl_pkg::REGION_W-1:0]     s_region_id,
    input  logic [iprl_pkg::ADDR_W-1:0]       s_ip_address,
    output logic                              m_found,
    output logic [iprl_pkg::REGION_W-1:0]     m_match_region
);

    // table memory: {start, end, region}
    logic [iprl_pkg::WORD_W-1:0] mem [iprl_pkg::TABLE_DEPTH];

    logic [iprl_pkg::CNT_W-1:0]    count_reg;
    logic [iprl_pkg::ADDR_W-1:0]   addr_reg;
    logic [iprl_pkg::CNT_W-1:0]    lo_reg, hi_reg, mid_reg;
    logic [iprl_pkg::WORD_W-1:0]   rd_reg;
    logic                          res_found_reg;
    logic [iprl_pkg::REGION_W-1:0] res_region_reg;
    logic                          found_reg;
    logic [iprl_pkg::REGION_W-1:0] region_reg;

    logic [iprl_pkg::CNT_W-1:0]    lo_next, hi_next, mid_next, active_cnt;
    logic [iprl_pkg::ADDR_W-1:0]   cur_addr;
    logic [iprl_pkg::ADDR_W-1:0]   rd_start, rd_end;
    logic [iprl_pkg::REGION_W-1:0] rd_region;
    logic [iprl_pkg::IDX_W-1:0]    rd_addr;
    logic                          start_le;

    assign rd_start  = rd_reg[iprl_pkg::WORD_W-1 -: iprl_pkg::ADDR_W];
    assign rd_end    = rd_reg[iprl_pkg::REGION_W +: iprl_pkg::ADDR_W];
    assign rd_region = rd_reg[iprl_pkg::REGION_W-1:0];

    // clamp count to table depth
    assign active_cnt = (count_reg > iprl_pkg::DEPTH_CNT) ? iprl_pkg::DEPTH_CNT : count_reg;

    assign cur_addr = cmd.start ? s_ip_address : addr_reg;
    assign start_le = (rd_start <= addr_reg);

    // next search interval
    always_comb begin
        if (cmd.start) begin
            lo_next = '0;
            hi_next = active_cnt;
        end else if (start_le) begin
            lo_next = mid_reg + iprl_pkg::CNT_W'(1);
            hi_next = hi_reg;
        end else begin
            lo_next = lo_reg;
            hi_next = mid_reg;
        end
    end

    // next probe point, or the selected entry when the interval is closed
    always_comb begin
        mid_next = lo_next + ((hi_next - lo_next) >> 1);
        status.probe_next = (lo_next < hi_next);
        status.empty_next = (lo_next == '0);
        if (status.probe_next) begin
            rd_addr = mid_next[iprl_pkg::IDX_W-1:0];
        end else begin
            rd_addr = lo_next[iprl_pkg::IDX_W-1:0] - iprl_pkg::IDX_W'(1);
        end
    end

    // table write and registered read
    always_ff @(posedge aclk) begin
        if (cmd.wr) begin
            mem[s_entry_index] <= {s_range_start, s_range_end, s_region_id};
        end
        if (cmd.start || cmd.step) begin
            rd_reg <= mem[rd_addr];
        end
    end

    // entry count register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (cfg_we) begin
            count_reg <= cfg_entry_count;
        end
    end

    // search registers
    always_ff @(posedge aclk) begin
        if (cmd.start || cmd.step) begin
            addr_reg <= cur_addr;
            lo_reg   <= lo_next;
            hi_reg   <= hi_next;
            mid_reg  <= mid_next;
        end
    end

    // result and output registers
    always_ff @(posedge aclk) begin
        if (cmd.res_miss) begin
            res_found_reg  <= 1'b0;
            res_region_reg <= '0;
        end else if (cmd.res_check) begin
            if (rd_start <= addr_reg && addr_reg <= rd_end) begin
                res_found_reg  <= 1'b1;
                res_region_reg <= rd_region;
            end else begin
                res_found_reg  <= 1'b0;
                res_region_reg <= '0;
            end
        end
        if (cmd.out_load) begin
            found_reg  <= res_found_reg;
            region_reg <= res_region_reg;
        end
    end

    assign m_found        = found_reg;
    assign m_match_region = region_reg;

endmodule

// ----- rtl/core/iprl_ctrl.sv -----
module iprl_ctrl (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic                   s_command,
    output logic                   m_valid,
    input  logic                   m_ready,
    output iprl_pkg::iprl_cmd_t    cmd,
    input  iprl_pkg::iprl_status_t status
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PROBE,
        ST_CHECK,
        ST_DONE
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;

    // next state and datapath commands
    always_comb begin
        cmd          = '0;
        state_next   = state_reg;
        m_valid_next = m_valid_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    if (s_command == iprl_pkg::CMD_WRITE) begin
                        cmd.wr = 1'b1;
                    end else begin
                        cmd.start = 1'b1;
                    end
                end
            end
            ST_PROBE: begin
                cmd.step = 1'b1;
            end
            ST_CHECK: begin
                cmd.res_check = 1'b1;
                state_next    = ST_DONE;
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.out_load = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
        // branch on the search interval after a start or a probe
        if (cmd.start || cmd.step) begin
            if (status.probe_next) begin
                state_next = ST_PROBE;
            end else if (status.empty_next) begin
                cmd.res_miss = 1'b1;
                state_next   = ST_DONE;
            end else begin
                state_next = ST_CHECK;
            end
        end
    end

    // state and output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;

endmodule

// ----- rtl/core/ip_range_region_lookup.sv -----
// a write transaction is taken in the idle state; a lookup runs k binary search
// probes (k at most ceil(log2(count + 1)), 11 for a full table of 1024 entries),
// then a range check on the selected entry if one qualifies, then output load
// throughput: one write per cycle while idle; the next lookup is accepted only once
// the last has loaded its result; probes run one per cycle on the single read port
// reset: synchronous active low; clears control and entry count, not the table
module ip_range_region_lookup (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_command,
    input  logic [iprl_pkg::IDX_W-1:0]        s_entry_index,
    input  logic [iprl_pkg::ADDR_W-1:0]       s_range_start,
    input  logic [iprl_pkg::ADDR_W-1:0]       s_range_end,
    input  logic [iprl_pkg::REGION_W-1:0]     s_region_id,
    input  logic [iprl_pkg::ADDR_W-1:0]       s_ip_address,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic                              m_found,
    output logic [iprl_pkg::REGION_W-1:0]     m_match_region,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [iprl_pkg::CNT_W-1:0]        cfg_entry_count
);

    iprl_pkg::iprl_cmd_t    cmd;
    iprl_pkg::iprl_status_t status;

    // configuration register always takes a transaction
    assign cfg_ready = 1'b1;

    iprl_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_command (s_command),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .cmd       (cmd),
        .status    (status)
    );

    iprl_dp u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .status          (status),
        .cfg_we          (cfg_valid),
        .cfg_entry_count (cfg_entry_count),
        .s_entry_index   (s_entry_index),
        .s_range_start   (s_range_start),
        .s_range_end     (s_range_end),
        .s_region_id     (s_region_id),
        .s_ip_address    (s_ip_address),
        .m_found         (m_found),
        .m_match_region  (m_match_region)
    );

endmodule
